>>> hw/rtl/tjc_pkg.sv
`timescale 1ns / 1ps

package tjc_pkg;

  localparam int unsigned CHAR_W = 8;

  typedef logic [CHAR_W-1:0] char_t;

  // Character codes that the classification rules single out.
  localparam char_t CH_QUOTE   = 8'h22;
  localparam char_t CH_DOLLAR  = 8'h24;
  localparam char_t CH_PERCENT = 8'h25;
  localparam char_t CH_APOS    = 8'h27;
  localparam char_t CH_LPAREN  = 8'h28;
  localparam char_t CH_RPAREN  = 8'h29;
  localparam char_t CH_COMMA   = 8'h2C;
  localparam char_t CH_DASH    = 8'h2D;
  localparam char_t CH_PERIOD  = 8'h2E;
  localparam char_t CH_ZERO    = 8'h30;
  localparam char_t CH_NINE    = 8'h39;
  localparam char_t CH_COLON   = 8'h3A;
  localparam char_t CH_SEMI    = 8'h3B;
  localparam char_t CH_QUEST   = 8'h3F;
  localparam char_t CH_UP_A    = 8'h41;
  localparam char_t CH_UP_I    = 8'h49;
  localparam char_t CH_BTICK   = 8'h60;
  localparam char_t CH_LO_A    = 8'h61;
  localparam char_t CH_LO_I    = 8'h69;
  localparam char_t CH_LO_S    = 8'h73;
  localparam char_t CH_LO_T    = 8'h74;
  localparam char_t CH_LO_Z    = 8'h7A;
  localparam char_t CASE_BIT   = 8'h20;

  // Sticky per-word flags.
  typedef struct packed {
    logic letter_seen;
    logic digit_seen;
    logic non_comma_seen;
    logic odd_seen;
    logic apostrophe_pending;
  } flags_t;

  function automatic logic is_letter(input char_t c);
    char_t lower;
    lower = c | CASE_BIT;
    return (lower >= CH_LO_A) && (lower <= CH_LO_Z);
  endfunction

  function automatic logic is_digit(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Punctuation that is fine as the last character of a word.
  function automatic logic ok_at_end(input char_t c);
    return (c == CH_PERIOD) || (c == CH_COMMA) || (c == CH_COLON) ||
           (c == CH_QUOTE) || (c == CH_SEMI) || (c == CH_APOS) ||
           (c == CH_QUEST) || (c == CH_PERCENT) || (c == CH_RPAREN);
  endfunction

  // Punctuation that is fine as the first character of a word.
  function automatic logic ok_at_start(input char_t c);
    return (c == CH_QUOTE) || (c == CH_APOS) || (c == CH_DOLLAR) ||
           (c == CH_BTICK) || (c == CH_LPAREN);
  endfunction

  // One-character words that are real words (or a lone dash).
  function automatic logic ok_single(input char_t c);
    return (c == CH_UP_A) || (c == CH_LO_A) || (c == CH_UP_I) ||
           (c == CH_LO_I) || (c == CH_DASH);
  endfunction

endpackage

>>> hw/rtl/token_junk_classifier.sv
`timescale 1ns / 1ps

// Word junk classifier.
// The input channel (in_valid / in_ready) carries one character of a
// whitespace-free word per transaction, with is_first and is_last marking
// the word's boundaries. The output channel (out_valid / out_ready) carries
// one transaction per word, on the word's last character, whose is_junky bit
// is the verdict. Characters that are not last produce no output.
// A character is captured in an input register; short logic then updates the
// sticky word flags and, for a last character, forms the verdict, which is
// loaded into the output register as soon as that register is free; the
// output transaction completes when the receiver accepts the verdict.
// Throughput is one character per cycle; the only limit is the single output
// register, which is shared with the next word's verdict.
// When the receiver stalls, characters that are not last keep flowing; a last
// character waits in the input register until the output register frees,
// and in_ready stays low while it waits.
// The synchronous reset rst clears the valid bits and all word flags; the
// payload registers keep whatever they held.
module token_junk_classifier (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [tjc_pkg::CHAR_W-1:0] char_code,
  input  logic                   is_first,
  input  logic                   is_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   is_junky
);

  // Input register.
  logic                s1_valid;
  tjc_pkg::char_t      s1_char;
  logic                s1_first;
  logic                s1_last;

  // Word flags as left by the characters processed so far.
  tjc_pkg::flags_t     flags;
  tjc_pkg::flags_t     flags_next;
  tjc_pkg::flags_t     cur;

  logic out_free;
  logic s1_go;
  logic s1_fire;
  logic verdict;

  assign out_free = !out_valid || out_ready;
  // A character that is not last needs no room at the output.
  assign s1_go    = !s1_last || out_free;
  assign s1_fire  = s1_valid && s1_go;
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_char  <= char_code;
      s1_first <= is_first;
      s1_last  <= is_last;
    end
  end

  // Flag update for the character in the input register.
  always_comb begin
    cur = s1_first ? '0 : flags;

    // An apostrophe inside the word is only fine as a final 't or 's.
    if (cur.apostrophe_pending) begin
      if (!(s1_last && ((s1_char == tjc_pkg::CH_LO_T) ||
                        (s1_char == tjc_pkg::CH_LO_S)))) begin
        cur.odd_seen = 1'b1;
      end
      cur.apostrophe_pending = 1'b0;
    end

    if (tjc_pkg::is_letter(s1_char)) begin
      cur.letter_seen = 1'b1;
    end else if (tjc_pkg::is_digit(s1_char)) begin
      cur.digit_seen = 1'b1;
    end else begin
      if (s1_char != tjc_pkg::CH_COMMA) begin
        cur.non_comma_seen = 1'b1;
      end
      if (s1_last && tjc_pkg::ok_at_end(s1_char)) begin
        cur.odd_seen = cur.odd_seen;
      end else if (s1_first && tjc_pkg::ok_at_start(s1_char)) begin
        cur.odd_seen = cur.odd_seen;
      end else if ((s1_char == tjc_pkg::CH_PERIOD) && !s1_first) begin
        cur.odd_seen = cur.odd_seen;
      end else if (s1_char == tjc_pkg::CH_DASH) begin
        cur.odd_seen = cur.odd_seen;
      end else if ((s1_char == tjc_pkg::CH_APOS) && !s1_last) begin
        cur.apostrophe_pending = 1'b1;
      end else begin
        cur.odd_seen = 1'b1;
      end
    end

    // The first matching rule decides the verdict.
    if (s1_first && !tjc_pkg::ok_single(s1_char)) begin
      verdict = 1'b1;
    end else if (cur.digit_seen && !cur.letter_seen && !cur.non_comma_seen) begin
      verdict = 1'b0;
    end else if (cur.letter_seen && cur.digit_seen) begin
      verdict = 1'b1;
    end else begin
      verdict = cur.odd_seen;
    end

    // Flags start fresh after a word ends.
    flags_next = s1_last ? '0 : cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (s1_fire) begin
      flags <= flags_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      is_junky <= verdict;
    end
  end

  // The flags are clear after a word's last character has been processed.
  a_flags_clear_after_word: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> flags == '0)
    else $error("word flags not cleared after the last character");

  // A character that is not last never creates an output transaction.
  a_no_result_mid_word: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_last && (!out_valid || out_ready) |=> !out_valid)
    else $error("output produced for a character that is not last");

  // The input only stalls behind a finished word whose verdict is blocked.
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s1_last && out_valid && !out_ready)
    else $error("input stalled without a blocked verdict");

  // A one-character word made of a plain letter other than A or I is junk; checked here for t.
  a_single_char_junk: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_first && s1_last && (s1_char == tjc_pkg::CH_LO_T)
    |=> out_valid && is_junky)
    else $error("one-character word not reported as junk");

endmodule
